@@ rtl/core/assert_macros.svh @@
// Assertion wrappers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_IMPLY(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/scas_pkg.sv @@
package scas_pkg;

  localparam int POOL_COUNT          = 5;
  localparam int MAX_SLOTS           = 256;
  localparam int SMALLEST_SLOT_BYTES = 16;
  localparam int WORD_BITS           = 32;

  localparam int SLOT_W         = $clog2(MAX_SLOTS);
  localparam int CNT_W          = SLOT_W + 1;
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int WIDX_W         = SLOT_W - BIT_W;
  localparam int WORDS_PER_POOL = MAX_SLOTS / WORD_BITS;
  localparam int MEM_WORDS      = POOL_COUNT * WORDS_PER_POOL;
  localparam int POOL_SEL_W     = $clog2(POOL_COUNT);
  localparam int POOL_CNT_W     = $clog2(POOL_COUNT + 1);
  localparam int ADDR_W         = POOL_SEL_W + WIDX_W;
  localparam int CLR_W          = $clog2(MEM_WORDS);
  localparam int MOD_CNT_W      = $clog2(SLOT_W);

  // item field widths
  localparam int LEN_W     = 9;
  localparam int POOL_W    = 3;
  localparam int GSLOT_W   = 8;
  localparam int TOTAL_W   = 11;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_COUNT = 5;

  localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
    CFG_W'(256), CFG_W'(256), CFG_W'(128), CFG_W'(128), CFG_W'(64)
  };

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [LEN_W-1:0]   request_length;
    logic [POOL_W-1:0]  free_pool;
    logic [GSLOT_W-1:0] free_slot;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [POOL_W-1:0]  granted_pool;
    logic [GSLOT_W-1:0] granted_slot;
    logic [TOTAL_W-1:0] total_in_use;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [WIDX_W-1:0]    widx;
    logic [SLOT_W-1:0]    start;
    logic [CNT_W-1:0]     limit;
    logic                 wrap;
  } scan_req_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POOL,
    S_MOD,
    S_RD,
    S_EXAM,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_t;

endpackage

@@ rtl/core/scas_occ_ram.sv @@
module scas_occ_ram (
  input  logic                            clk,
  input  scas_pkg::mem_wr_t               wr,
  input  logic [scas_pkg::ADDR_W-1:0]     raddr,
  output logic [scas_pkg::WORD_BITS-1:0]  rdata
);
  import scas_pkg::*;

  logic [WORD_BITS-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/scas_scan_unit.sv @@
module scas_scan_unit (
  input  scas_pkg::scan_req_t req,
  output scas_pkg::scan_rsp_t rsp
);
  import scas_pkg::*;

  // lowest free slot of one occupancy word inside the search window
  always_comb begin
    logic [SLOT_W-1:0] slot_b;
    logic              in_win;
    rsp    = '0;
    slot_b = '0;
    in_win = 1'b0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      slot_b = {req.widx, BIT_W'(b)};
      if (req.wrap) begin
        in_win = slot_b < req.start;
      end else begin
        in_win = (slot_b >= req.start) && ({1'b0, slot_b} < req.limit);
      end
      if (!req.word[b] && in_win) begin
        rsp.found   = 1'b1;
        rsp.bit_idx = BIT_W'(b);
      end
    end
  end

endmodule

@@ rtl/core/scas_ctrl.sv @@
`include "assert_macros.svh"

module scas_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scas_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output scas_pkg::out_item_t              out_data,
  input  logic [scas_pkg::CNT_W-1:0]       usable [scas_pkg::POOL_COUNT],
  output scas_pkg::mem_wr_t                mem_wr,
  output logic [scas_pkg::ADDR_W-1:0]      raddr,
  input  logic [scas_pkg::WORD_BITS-1:0]   rdata,
  output scas_pkg::scan_req_t              scan_req,
  input  scas_pkg::scan_rsp_t              scan_rsp
);
  import scas_pkg::*;

  state_t state, state_next;

  logic [CLR_W-1:0]      clr;
  logic [POOL_CNT_W-1:0] p;
  logic [SLOT_W-1:0]     start;
  logic [CNT_W-1:0]      nreg;
  logic [WIDX_W-1:0]     w;
  logic                  wrap;
  logic [MOD_CNT_W-1:0]  mcnt;
  logic [CNT_W-1:0]      rem;
  logic [SLOT_W-1:0]     slot_reg;
  logic [SLOT_W-1:0]     nfs      [POOL_COUNT];
  logic [CNT_W-1:0]      pool_use [POOL_COUNT];
  logic [TOTAL_W-1:0]    all_use;
  status_t               res_status;
  logic [POOL_W-1:0]     res_pool;
  logic [GSLOT_W-1:0]    res_slot;

  logic [POOL_SEL_W-1:0] p_sel;
  logic                  p_done;
  logic [CNT_W-1:0]      n_cur;
  logic [SLOT_W-1:0]     nfs_cur;
  logic [LEN_W:0]        need;
  logic                  too_long;
  logic [POOL_CNT_W-1:0] first_pool;
  logic                  free_null;
  logic                  free_bad;
  logic [CNT_W-1:0]      mod_tmp;
  logic [CNT_W-1:0]      mod_next;
  logic [CNT_W-1:0]      n_minus;
  logic [WIDX_W-1:0]     last_w;
  logic [WIDX_W-1:0]     start_w;
  logic [SLOT_W-1:0]     gslot;
  logic                  scan_end;
  logic                  out_load;
  logic                  free_hit;

  assign p_sel   = p[POOL_SEL_W-1:0];
  assign p_done  = p == POOL_CNT_W'(POOL_COUNT);
  assign n_cur   = usable[p_sel];
  assign nfs_cur = nfs[p_sel];

  assign need      = {1'b0, in_data.request_length} + 1'b1;
  assign too_long  = int'(need) > (SMALLEST_SLOT_BYTES << (POOL_COUNT - 1));
  assign free_null = in_data.free_pool == '0;
  assign free_bad  = (int'(in_data.free_pool) > POOL_COUNT) ||
                     (int'(in_data.free_slot) >= MAX_SLOTS);

  always_comb begin
    first_pool = '0;
    for (int i = POOL_COUNT - 1; i >= 0; i--) begin
      if (int'(need) <= (SMALLEST_SLOT_BYTES << i)) begin
        first_pool = POOL_CNT_W'(i);
      end
    end
  end

  // one restoring step of next-fit pointer mod slot count
  assign mod_tmp  = {rem[SLOT_W-1:0], nfs_cur[mcnt]};
  assign mod_next = (mod_tmp >= nreg) ? (mod_tmp - nreg) : mod_tmp;

  assign n_minus  = nreg - 1'b1;
  assign last_w   = n_minus[SLOT_W-1:BIT_W];
  assign start_w  = start[SLOT_W-1:BIT_W];
  assign gslot    = {w, scan_rsp.bit_idx};
  assign scan_end = wrap ? (w == start_w) : ((w == last_w) && (start == '0));
  assign out_load = !out_valid || out_ready;
  assign free_hit = rdata[slot_reg[BIT_W-1:0]];

  assign scan_req.word  = rdata;
  assign scan_req.widx  = w;
  assign scan_req.start = start;
  assign scan_req.limit = nreg;
  assign scan_req.wrap  = wrap;

  assign raddr = {p_sel, w};

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == CLR_W'(MEM_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_ALLOC) begin
            state_next = too_long ? S_RESP : S_POOL;
          end else if (free_null || free_bad) begin
            state_next = S_RESP;
          end else begin
            state_next = S_FREE_RD;
          end
        end
      end
      S_POOL: begin
        if (p_done) begin
          state_next = S_RESP;
        end else if (n_cur != '0) begin
          state_next = ({1'b0, nfs_cur} < n_cur) ? S_RD : S_MOD;
        end
      end
      S_MOD: begin
        if (mcnt == '0) state_next = S_RD;
      end
      S_RD: state_next = S_EXAM;
      S_EXAM: begin
        if (scan_rsp.found) begin
          state_next = S_RESP;
        end else if (scan_end) begin
          state_next = S_POOL;
        end else begin
          state_next = S_RD;
        end
      end
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: state_next = S_RESP;
      S_RESP: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_wr   = '0;
    case (state)
      S_CLEAR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = ADDR_W'(clr);
      end
      S_IDLE: in_ready = 1'b1;
      S_EXAM: begin
        mem_wr.we   = scan_rsp.found;
        mem_wr.addr = raddr;
        mem_wr.data = rdata | (WORD_BITS'(1) << scan_rsp.bit_idx);
      end
      S_FREE_CHK: begin
        mem_wr.we   = free_hit;
        mem_wr.addr = raddr;
        mem_wr.data = rdata & ~(WORD_BITS'(1) << slot_reg[BIT_W-1:0]);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      all_use   <= '0;
      for (int i = 0; i < POOL_COUNT; i++) begin
        nfs[i]      <= '0;
        pool_use[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_RESP && out_load) begin
        out_valid <= 1'b1;
        out_data  <= '{status: res_status, granted_pool: res_pool,
                       granted_slot: res_slot, total_in_use: all_use};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (in_valid) begin
            res_status <= ST_OK;
            res_pool   <= '0;
            res_slot   <= '0;
            slot_reg   <= SLOT_W'(in_data.free_slot);
            if (in_data.func == FUNC_ALLOC) begin
              p <= first_pool;
              if (too_long) res_status <= ST_NO_SPACE;
            end else if (!free_null) begin
              if (free_bad) begin
                res_status <= ST_BAD_FREE;
              end else begin
                p <= POOL_CNT_W'(in_data.free_pool - 1'b1);
                w <= in_data.free_slot[SLOT_W-1:BIT_W];
              end
            end
          end
        end
        S_POOL: begin
          if (p_done) begin
            res_status <= ST_NO_SPACE;
          end else if (n_cur == '0) begin
            p <= p + 1'b1;
          end else begin
            nreg <= n_cur;
            wrap <= 1'b0;
            if ({1'b0, nfs_cur} < n_cur) begin
              start <= nfs_cur;
              w     <= nfs_cur[SLOT_W-1:BIT_W];
            end else begin
              rem  <= '0;
              mcnt <= MOD_CNT_W'(SLOT_W - 1);
            end
          end
        end
        S_MOD: begin
          rem  <= mod_next;
          mcnt <= mcnt - 1'b1;
          if (mcnt == '0) begin
            start <= mod_next[SLOT_W-1:0];
            w     <= mod_next[SLOT_W-1:BIT_W];
          end
        end
        S_EXAM: begin
          if (scan_rsp.found) begin
            nfs[p_sel]      <= gslot;
            pool_use[p_sel] <= pool_use[p_sel] + 1'b1;
            all_use         <= all_use + 1'b1;
            res_pool        <= POOL_W'(p + 1'b1);
            res_slot        <= GSLOT_W'(gslot);
          end else if (scan_end) begin
            p <= p + 1'b1;
          end else if (!wrap && w == last_w) begin
            wrap <= 1'b1;
            w    <= '0;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_FREE_CHK: begin
          if (!free_hit) begin
            res_status <= ST_BAD_FREE;
          end else begin
            if (pool_use[p_sel] != '0) pool_use[p_sel] <= pool_use[p_sel] - 1'b1;
            if (all_use != '0) all_use <= all_use - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `CHK_IMPLY(a_wr_state, mem_wr.we, (state == S_CLEAR) || (state == S_EXAM) || (state == S_FREE_CHK), "occupancy write outside clear, grant or free")
  `CHK_IMPLY(a_wr_range, mem_wr.we, int'(mem_wr.addr) < MEM_WORDS, "occupancy write beyond memory")
  `CHK_NEXT(a_grant_count, (state == S_EXAM) && scan_rsp.found, all_use == $past(all_use) + 1'b1, "grant did not bump total")
  `CHK_IMPLY(a_fail_no_pool, out_valid && (out_data.status != ST_OK), out_data.granted_pool == '0, "failed item carries a pool")

endmodule

@@ rtl/core/size_class_slot_allocator_unit.sv @@
// Alloc: pool selection, restoring reduction of the next-fit pointer mod slot count when it is
//   at or past that count, then read and scan of occupancy words, moving on to further pools;
//   free reads and checks one word; null or invalid free and oversize alloc go straight to the
//   response, which a stalled output holds. One item at a time; in_ready only in idle, entered
//   as the result is registered. Scan rate set by one memory read port and the 32-bit scan unit.
// Reset (sync, rst high): 40-word clearing pass, in_ready low; config writes taken throughout.
module size_class_slot_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scas_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output scas_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [scas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scas_pkg::CFG_W-1:0]       cfg_data
);
  import scas_pkg::*;

  logic [CFG_W-1:0]     cfg_slots [POOL_COUNT];
  logic [CNT_W-1:0]     usable    [POOL_COUNT];
  mem_wr_t              mem_wr;
  logic [ADDR_W-1:0]    raddr;
  logic [WORD_BITS-1:0] rdata;
  scan_req_t            scan_req;
  scan_rsp_t            scan_rsp;

  for (genvar i = 0; i < POOL_COUNT; i++) begin : g_cfg
    if (i < CFG_COUNT) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          cfg_slots[i] <= CFG_RESET[i];
        end else if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
          cfg_slots[i] <= cfg_data;
        end
      end
    end else begin : g_fixed
      assign cfg_slots[i] = CFG_W'(MAX_SLOTS);
    end
    assign usable[i] = (int'(cfg_slots[i]) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
                                                        : CNT_W'(cfg_slots[i]);
  end

  scas_occ_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  scas_scan_unit u_scan (
    .req (scan_req),
    .rsp (scan_rsp)
  );

  scas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .usable    (usable),
    .mem_wr    (mem_wr),
    .raddr     (raddr),
    .rdata     (rdata),
    .scan_req  (scan_req),
    .scan_rsp  (scan_rsp)
  );

endmodule
